// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the MIDI route core. The user module must
// have clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MCR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define MCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/core/mcr_pkg.sv -----
// ---------------------------------------------------------------------------
// mcr_pkg
// Types and constants of the MIDI controller router.
// ---------------------------------------------------------------------------
package mcr_pkg;

  localparam int ROUTE_SLOTS_DEF = 16;
  localparam int MAX_EVENTS      = 16;
  localparam int EV_W            = $clog2(MAX_EVENTS + 1);

  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 80;

  localparam logic [3:0]  MIDI_TYPE_CC    = 4'hB;
  localparam logic [3:0]  MIDI_TYPE_PC    = 4'hC;
  localparam logic [31:0] PC_TARGET_PARAM = 32'hFFFF_FFFF;

  // Divide-by-127 runs on base-128 digits of a 42-bit magnitude.
  localparam int NUM_W      = 42;
  localparam int DIV_DIGITS = 6;
  localparam logic [7:0] DIVISOR = 8'd127;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_MIDI  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RK_ADDED   = 2'd0,
    RK_FULL    = 2'd1,
    RK_CLEARED = 2'd2,
    RK_EVENT   = 2'd3
  } result_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_RD,
    S_CHK,
    S_SCALE,
    S_PUSH,
    S_FLUSH
  } ctl_state_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_SUM,
    SC_DIV,
    SC_DONE
  } scale_state_t;

  typedef struct packed {
    logic [3:0]         channel;
    logic               kind;
    logic [6:0]         number;
    logic [7:0]         node;
    logic [31:0]        param;
    logic signed [31:0] low;
    logic signed [31:0] high;
  } route_entry_t;

  typedef struct packed {
    logic               start;
    logic [6:0]         data2;
    logic signed [31:0] low;
    logic signed [31:0] high;
  } scale_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] value;
  } scale_rsp_t;

endpackage

// ----- rtl/core/mcr_route_ram.sv -----
// ---------------------------------------------------------------------------
// mcr_route_ram
// Route table: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module mcr_route_ram
  import mcr_pkg::*;
#(
  parameter int ROUTE_SLOTS = ROUTE_SLOTS_DEF,
  localparam int IDX_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  route_entry_t     wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output route_entry_t     rd_data
);

  route_entry_t mem [ROUTE_SLOTS];
  route_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds between reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/mcr_cc_scale.sv -----
// ---------------------------------------------------------------------------
// mcr_cc_scale
// Control change scaler: (127*low + data2*(high-low)) / 127, truncated
// toward zero. Multiply, sum, six base-128 divide digits, sign fix.
// ---------------------------------------------------------------------------
module mcr_cc_scale
  import mcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  scale_req_t req,
  output scale_rsp_t rsp
);

  scale_state_t st_r, st_nxt;

  logic signed [40:0]  prod_r;
  logic signed [39:0]  lo127_r;
  logic [NUM_W-1:0]    mag_r;
  logic [NUM_W-1:0]    q_r;
  logic [6:0]          rem_r;
  logic                neg_r;
  logic [2:0]          dig_r;

  logic signed [7:0]       d2_s;
  logic signed [32:0]      diff;
  logic signed [39:0]      lo40;
  logic signed [NUM_W-1:0] num;
  logic [6:0]              digit;
  logic [7:0]              dsum;
  logic                    carry;
  logic [6:0]              q_dig;
  logic [6:0]              rem_new;

  assign d2_s  = signed'({1'b0, req.data2});
  assign diff  = {req.high[31], req.high} - {req.low[31], req.low};
  assign lo40  = 40'(req.low);
  assign num   = NUM_W'(prod_r) + NUM_W'(lo127_r);

  // One long-division digit: t = 128*rem + digit, rem < 127.
  assign digit   = mag_r[NUM_W-1 -: 7];
  assign dsum    = {1'b0, rem_r} + {1'b0, digit};
  assign carry   = (dsum >= DIVISOR);
  assign q_dig   = rem_r + 7'(carry);
  assign rem_new = carry ? 7'(dsum - DIVISOR) : dsum[6:0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      SC_IDLE: if (req.start) st_nxt = SC_SUM;
      SC_SUM:  st_nxt = SC_DIV;
      SC_DIV:  if (dig_r == 3'(DIV_DIGITS - 1)) st_nxt = SC_DONE;
      SC_DONE: st_nxt = SC_IDLE;
      default: st_nxt = SC_IDLE;
    endcase
  end

  always_comb begin
    rsp.done  = (st_r == SC_DONE);
    rsp.value = neg_r ? -signed'(q_r[31:0]) : signed'(q_r[31:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SC_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      SC_IDLE: begin
        if (req.start) begin
          prod_r  <= 41'(d2_s) * 41'(diff);
          lo127_r <= (lo40 <<< 7) - lo40;
        end
      end
      SC_SUM: begin
        neg_r <= num[NUM_W-1];
        mag_r <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        q_r   <= '0;
        rem_r <= '0;
        dig_r <= '0;
      end
      SC_DIV: begin
        q_r   <= {q_r[NUM_W-8:0], q_dig};
        mag_r <= mag_r << 7;
        rem_r <= rem_new;
        dig_r <= dig_r + 3'd1;
      end
      SC_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/midi_controller_router.sv -----
// ---------------------------------------------------------------------------
// midi_controller_router
// MIDI route table with in-order scan, emitting one parameter event per
// matching route, up to MAX_EVENTS per message.
// ---------------------------------------------------------------------------
//  channel  dir  tdata bits                      tuser        tlast
//  in_      in   op-dependent item, 144 bits     op           -
//  out_     out  slot/node/param/value, 80 bits  result_kind  last result
//
//  Add, clear: take the beat, then post the result.
//  MIDI: take the beat, then per scanned route a RAM read and a compare;
//  a program change hit adds a push, a control change hit adds the scaler
//  (sum, six divide digits, sign fix) and a push; a bound check and a flush end it.
//  Reset: synchronous, active low; table becomes empty, no RAM sweep.
//  Stalls: out_ backpressure holds the scan; in_ waits for the last result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module midi_controller_router
  import mcr_pkg::*;
#(
  parameter int ROUTE_SLOTS = ROUTE_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata, low bit up: status[7:0], data1[14:8], data2[21:15],
  // route_channel[25:22], route_kind[26], route_number[33:27],
  // route_node[41:34], route_param[73:42], route_low[105:74],
  // route_high[137:106], zero pad[143:138]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,   // op[1:0]
  // out_tdata, low bit up: slot[3:0], node_index[11:4], target_param[43:12],
  // value[75:44], zero pad[79:76]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser,  // result_kind[1:0]
  output logic                   out_tlast   // last result of the beat
);

  localparam int IDX_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  localparam int CNT_W = $clog2(ROUTE_SLOTS + 1);

  // Input beat fields
  op_t                f_op;
  logic [7:0]         f_status;
  logic [6:0]         f_data1;
  logic [6:0]         f_data2;
  route_entry_t       f_route;

  assign f_op            = op_t'(in_tuser);
  assign f_status        = in_tdata[7:0];
  assign f_data1         = in_tdata[14:8];
  assign f_data2         = in_tdata[21:15];
  assign f_route.channel = in_tdata[25:22];
  assign f_route.kind    = in_tdata[26];
  assign f_route.number  = in_tdata[33:27];
  assign f_route.node    = in_tdata[41:34];
  assign f_route.param   = in_tdata[73:42];
  assign f_route.low     = signed'(in_tdata[105:74]);
  assign f_route.high    = signed'(in_tdata[137:106]);

  ctl_state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [EV_W-1:0]  ev_cnt_r, ev_cnt_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers
  logic [3:0]         msg_ch_r, msg_ch_nxt;
  logic               msg_pc_r, msg_pc_nxt;
  logic [6:0]         msg_d1_r, msg_d1_nxt;
  logic [6:0]         msg_d2_r, msg_d2_nxt;
  result_kind_t       resp_kind_r, resp_kind_nxt;
  logic [3:0]         resp_slot_r, resp_slot_nxt;
  logic signed [31:0] cand_value_r, cand_value_nxt;
  logic [7:0]         pend_node_r, pend_node_nxt;
  logic [31:0]        pend_param_r, pend_param_nxt;
  logic signed [31:0] pend_value_r, pend_value_nxt;
  result_kind_t       out_kind_r, out_kind_nxt;
  logic [3:0]         out_slot_r, out_slot_nxt;
  logic [7:0]         out_node_r, out_node_nxt;
  logic [31:0]        out_param_r, out_param_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;

  // Decoded control
  logic             in_acc;
  logic             midi_ok;
  logic             out_free;
  logic             scan_done;
  logic             hit_pc;
  logic             hit_cc;
  logic             push_go;
  logic             table_full;
  logic [CNT_W+3:0] slot_wide;

  // RAM and scaler hookup
  logic         ram_wr_en;
  logic         ram_rd_en;
  route_entry_t ram_rd_data;
  scale_req_t   scale_req;
  scale_rsp_t   scale_rsp;

  assign in_acc     = in_tvalid && in_tready;
  assign midi_ok    = (f_status[7:4] == MIDI_TYPE_CC) || (f_status[7:4] == MIDI_TYPE_PC);
  assign out_free   = !out_valid_r || out_tready;
  assign scan_done  = (scan_r >= count_r) || (ev_cnt_r == EV_W'(MAX_EVENTS));
  assign table_full = (count_r >= CNT_W'(ROUTE_SLOTS));
  assign slot_wide  = {4'b0000, count_r};

  // The kind stored in the route must agree with the message type.
  assign hit_pc = (ram_rd_data.channel == msg_ch_r) && msg_pc_r && ram_rd_data.kind;
  assign hit_cc = (ram_rd_data.channel == msg_ch_r) && !msg_pc_r && !ram_rd_data.kind
                  && (ram_rd_data.number == msg_d1_r);
  // A held event goes out before the new one takes its place.
  assign push_go = !pend_v_r || out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (f_op)
            OP_ADD, OP_CLEAR: state_nxt = S_RESP;
            OP_MIDI:          if (midi_ok) state_nxt = S_RD;
            OP_NONE:          state_nxt = S_IDLE;
            default:          state_nxt = S_IDLE;
          endcase
        end
      end
      S_RESP:  if (out_free) state_nxt = S_IDLE;
      S_RD:    state_nxt = scan_done ? S_FLUSH : S_CHK;
      S_CHK: begin
        priority if (hit_pc) state_nxt = S_PUSH;
        else if (hit_cc)     state_nxt = S_SCALE;
        else                 state_nxt = S_RD;
      end
      S_SCALE: if (scale_rsp.done) state_nxt = S_PUSH;
      S_PUSH:  if (push_go) state_nxt = S_RD;
      S_FLUSH: if (push_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_tready       = (state_r == S_IDLE);
    ram_wr_en       = (state_r == S_IDLE) && in_acc && (f_op == OP_ADD) && !table_full;
    ram_rd_en       = (state_r == S_RD) && !scan_done;
    scale_req.start = (state_r == S_CHK) && hit_cc;
    scale_req.data2 = msg_d2_r;
    scale_req.low   = ram_rd_data.low;
    scale_req.high  = ram_rd_data.high;
  end

  // Datapath next values
  always_comb begin
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    ev_cnt_nxt     = ev_cnt_r;
    pend_v_nxt     = pend_v_r;
    msg_ch_nxt     = msg_ch_r;
    msg_pc_nxt     = msg_pc_r;
    msg_d1_nxt     = msg_d1_r;
    msg_d2_nxt     = msg_d2_r;
    resp_kind_nxt  = resp_kind_r;
    resp_slot_nxt  = resp_slot_r;
    cand_value_nxt = cand_value_r;
    pend_node_nxt  = pend_node_r;
    pend_param_nxt = pend_param_r;
    pend_value_nxt = pend_value_r;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_node_nxt   = out_node_r;
    out_param_nxt  = out_param_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          msg_ch_nxt = f_status[3:0];
          msg_pc_nxt = (f_status[7:4] == MIDI_TYPE_PC);
          msg_d1_nxt = f_data1;
          msg_d2_nxt = f_data2;
          scan_nxt   = '0;
          ev_cnt_nxt = '0;
          unique case (f_op)
            OP_ADD: begin
              if (table_full) begin
                resp_kind_nxt = RK_FULL;
                resp_slot_nxt = 4'd0;
              end else begin
                resp_kind_nxt = RK_ADDED;
                resp_slot_nxt = slot_wide[3:0];
                count_nxt     = count_r + CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              resp_kind_nxt = RK_CLEARED;
              resp_slot_nxt = 4'd0;
              count_nxt     = '0;
            end
            OP_MIDI, OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = resp_kind_r;
          out_slot_nxt  = resp_slot_r;
          out_node_nxt  = '0;
          out_param_nxt = '0;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
        end
      end
      S_RD: begin
      end
      S_CHK: begin
        if (hit_pc) begin
          cand_value_nxt = signed'({9'd0, msg_d1_r, 16'd0});
        end else if (!hit_cc) begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end
      S_SCALE: begin
        if (scale_rsp.done) cand_value_nxt = scale_rsp.value;
      end
      S_PUSH: begin
        if (push_go) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = RK_EVENT;
            out_slot_nxt  = 4'd0;
            out_node_nxt  = pend_node_r;
            out_param_nxt = pend_param_r;
            out_value_nxt = pend_value_r;
            out_last_nxt  = 1'b0;
          end
          pend_v_nxt     = 1'b1;
          pend_node_nxt  = ram_rd_data.node;
          pend_param_nxt = msg_pc_r ? PC_TARGET_PARAM : ram_rd_data.param;
          pend_value_nxt = cand_value_r;
          ev_cnt_nxt     = ev_cnt_r + EV_W'(1);
          scan_nxt       = scan_r + CNT_W'(1);
        end
      end
      S_FLUSH: begin
        if (pend_v_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = RK_EVENT;
          out_slot_nxt  = 4'd0;
          out_node_nxt  = pend_node_r;
          out_param_nxt = pend_param_r;
          out_value_nxt = pend_value_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      ev_cnt_r    <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      ev_cnt_r    <= ev_cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    msg_ch_r     <= msg_ch_nxt;
    msg_pc_r     <= msg_pc_nxt;
    msg_d1_r     <= msg_d1_nxt;
    msg_d2_r     <= msg_d2_nxt;
    resp_kind_r  <= resp_kind_nxt;
    resp_slot_r  <= resp_slot_nxt;
    cand_value_r <= cand_value_nxt;
    pend_node_r  <= pend_node_nxt;
    pend_param_r <= pend_param_nxt;
    pend_value_r <= pend_value_nxt;
    out_kind_r   <= out_kind_nxt;
    out_slot_r   <= out_slot_nxt;
    out_node_r   <= out_node_nxt;
    out_param_r  <= out_param_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Writes happen only in idle and reads only while scanning, so the
  // two ports never touch the same entry in one cycle.
  mcr_route_ram #(
    .ROUTE_SLOTS (ROUTE_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (f_route),
    .rd_en   (ram_rd_en),
    .rd_addr (scan_r[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  mcr_cc_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (scale_req),
    .rsp   (scale_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_value_r, out_param_r, out_node_r, out_slot_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  `MCR_ASSERT_IMPL(a_count_range, 1'b1, count_r <= CNT_W'(ROUTE_SLOTS))
  `MCR_ASSERT_IMPL(a_idle_no_pend, state_r == S_IDLE, !pend_v_r)
  `MCR_ASSERT_IMPL(a_chk_in_range, state_r == S_CHK, scan_r < count_r)
  `MCR_ASSERT_IMPL(a_ev_bound, 1'b1, ev_cnt_r <= EV_W'(MAX_EVENTS))
  `MCR_ASSERT_NEXT(a_push_fills, (state_r == S_PUSH) && push_go, pend_v_r)

endmodule
